// ===== rtl/core/piq_pkg.sv =====
// Pin input qualifier package: shared types, constants and register codes.
// No dependencies; used by the interfaces, the step logic and the top level.
`default_nettype none

package piq_pkg;

    // Field widths fixed by the block's item format
    localparam int IN_W        = 10;
    localparam int LEVEL_W     = 10;
    localparam int ACC_W       = 15;
    localparam int HOLD_W      = 8;
    localparam int SHIFT_W     = 3;
    localparam int THRESH_W    = 8;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Default number of converter bits used from the raw sample
    localparam int SAMPLE_BITS = 10;

    localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(5);

    // Register reset values
    localparam logic [HOLD_W-1:0]   HOLDOFF_RST = HOLD_W'(5);
    localparam logic [SHIFT_W-1:0]  SHIFT_RST   = SHIFT_W'(2);
    localparam logic [THRESH_W-1:0] THRESH_RST  = THRESH_W'(6);

    // Pin modes; the spare code behaves as plain follow
    typedef enum logic [MODE_W-1:0] {
        MODE_DEBOUNCE = 2'd0,
        MODE_FOLLOW   = 2'd1,
        MODE_ANALOG   = 2'd2,
        MODE_SPARE    = 2'd3
    } t_pin_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIN_MODE  = 2'd0,
        REG_HOLDOFF   = 2'd1,
        REG_SHIFT     = 2'd2,
        REG_THRESHOLD = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_pin_mode             pin_mode;
        logic [HOLD_W-1:0]     holdoff_ticks;
        logic [SHIFT_W-1:0]    filter_shift;
        logic [THRESH_W-1:0]   change_threshold;
    } t_cfg;

    typedef struct packed {
        logic                  seeded;
        logic [HOLD_W-1:0]     holdoff_count;
        logic [ACC_W-1:0]      accumulator;
        logic [ACC_W-1:0]      last_reported;
    } t_state;

    typedef struct packed {
        logic [LEVEL_W-1:0]    level_value;
        logic                  changed;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/piq_if.sv =====
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on piq_pkg for field widths.
`default_nettype none

interface piq_sample_if;
    logic                       valid;
    logic                       ready;
    logic [piq_pkg::IN_W-1:0]   raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface piq_result_if;
    logic                         valid;
    logic                         ready;
    logic [piq_pkg::LEVEL_W-1:0]  level_value;
    logic                         changed;

    modport source (output valid, output level_value, output changed, input ready);
    modport sink   (input valid, input level_value, input changed, output ready);
endinterface

interface piq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [piq_pkg::CFG_IDX_W-1:0]   index;
    logic [piq_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pin_input_qualifier_core.sv =====
// Pin input qualifier top level: input register, one step of logic, result register.
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the result is drained; the state update sits between the two registers.
// Reset: synchronous, active low; clears state, pipeline valids and loads register defaults.
// Depends on piq_pkg, the channel interfaces in piq_if and piq_step.
`default_nettype none

module pin_input_qualifier_core #(
    parameter int SAMPLE_BITS = piq_pkg::SAMPLE_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    piq_sample_if.sink     i_sample,
    piq_cfg_if.sink        i_cfg,
    piq_result_if.source   o_result
);

    piq_pkg::t_cfg                 r_cfg;
    piq_pkg::t_state               r_state;
    piq_pkg::t_state               n_state;
    piq_pkg::t_result              n_result;
    piq_pkg::t_result              r_result;
    logic                          r_out_valid;
    logic                          r_in_valid;
    logic [piq_pkg::IN_W-1:0]      r_in_sample;
    logic                          advance;

    // Stage moves on when the result register is empty or being drained
    assign advance         = !r_out_valid || o_result.ready;
    assign i_sample.ready  = !r_in_valid || advance;
    assign i_cfg.ready     = 1'b1;

    assign o_result.valid       = r_out_valid;
    assign o_result.level_value = r_result.level_value;
    assign o_result.changed     = r_result.changed;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_mode         <= piq_pkg::MODE_DEBOUNCE;
            r_cfg.holdoff_ticks    <= piq_pkg::HOLDOFF_RST;
            r_cfg.filter_shift     <= piq_pkg::SHIFT_RST;
            r_cfg.change_threshold <= piq_pkg::THRESH_RST;
        end else if (i_cfg.valid) begin
            unique case (piq_pkg::t_cfg_reg'(i_cfg.index))
                piq_pkg::REG_PIN_MODE:
                    r_cfg.pin_mode <= piq_pkg::t_pin_mode'(i_cfg.data[piq_pkg::MODE_W-1:0]);
                piq_pkg::REG_HOLDOFF:
                    r_cfg.holdoff_ticks <= i_cfg.data[piq_pkg::HOLD_W-1:0];
                piq_pkg::REG_SHIFT:
                    r_cfg.filter_shift <= i_cfg.data[piq_pkg::SHIFT_W-1:0];
                piq_pkg::REG_THRESHOLD:
                    r_cfg.change_threshold <= i_cfg.data[piq_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Qualifier step
    piq_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_raw_sample (r_in_sample),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // Pipeline control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_in_sample <= i_sample.raw_sample;
        end
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/piq_step.sv =====
// One tick of the qualifier: next state and result from state, config and sample.
// Pure combinational; depends on piq_pkg.
`default_nettype none

module piq_step #(
    parameter int SAMPLE_BITS = piq_pkg::SAMPLE_BITS
) (
    input  wire  piq_pkg::t_cfg              i_cfg,
    input  wire  piq_pkg::t_state            i_state,
    input  wire  logic [piq_pkg::IN_W-1:0]   i_raw_sample,
    output piq_pkg::t_state                  o_state,
    output piq_pkg::t_result                 o_result
);

    localparam int SB_USED = (SAMPLE_BITS < piq_pkg::IN_W) ? SAMPLE_BITS : piq_pkg::IN_W;
    localparam int WIDE_W  = piq_pkg::ACC_W + 1;

    logic [piq_pkg::IN_W-1:0]      sample;
    logic [piq_pkg::SHIFT_W-1:0]   k;
    logic [WIDE_W-1:0]             seed_wide;
    logic [WIDE_W-1:0]             iir_wide;
    logic [piq_pkg::ACC_W-1:0]     seed_acc;
    logic [piq_pkg::ACC_W-1:0]     iir_acc;
    logic [piq_pkg::ACC_W-1:0]     delta;
    logic                          is_analog;

    // Masked sample and saturated filter shift
    assign sample    = piq_pkg::IN_W'(i_raw_sample[SB_USED-1:0]);
    assign k         = (i_cfg.filter_shift > piq_pkg::MAX_SHIFT) ? piq_pkg::MAX_SHIFT
                                                                 : i_cfg.filter_shift;
    assign is_analog = (i_cfg.pin_mode == piq_pkg::MODE_ANALOG);

    // Seed value and leaky integrator, both saturated to the accumulator range
    assign seed_wide = WIDE_W'(sample) << k;
    assign iir_wide  = WIDE_W'(i_state.accumulator) - WIDE_W'(i_state.accumulator >> k)
                     + WIDE_W'(sample);
    assign seed_acc  = seed_wide[WIDE_W-1] ? piq_pkg::ACC_MAX : seed_wide[WIDE_W-2:0];
    assign iir_acc   = iir_wide[WIDE_W-1]  ? piq_pkg::ACC_MAX : iir_wide[WIDE_W-2:0];

    // Distance of the new accumulator from the last reported value
    assign delta = (i_state.last_reported > iir_acc) ? i_state.last_reported - iir_acc
                                                     : iir_acc - i_state.last_reported;

    always_comb begin
        o_state          = i_state;
        o_result.changed = 1'b0;

        if (!i_state.seeded) begin
            // First tick: seed both values, no change reported
            o_state.seeded        = 1'b1;
            o_state.accumulator   = is_analog ? seed_acc : piq_pkg::ACC_W'(sample[0]);
            o_state.last_reported = o_state.accumulator;
        end else if (i_state.holdoff_count != '0) begin
            o_state.holdoff_count = i_state.holdoff_count - 1'b1;
        end else begin
            case (i_cfg.pin_mode)
                piq_pkg::MODE_DEBOUNCE: begin
                    o_state.accumulator = piq_pkg::ACC_W'(sample[0]);
                    if (i_state.last_reported != o_state.accumulator) begin
                        o_state.last_reported = o_state.accumulator;
                        o_state.holdoff_count = i_cfg.holdoff_ticks;
                        o_result.changed      = 1'b1;
                    end
                end
                piq_pkg::MODE_ANALOG: begin
                    o_state.accumulator = iir_acc;
                    if (delta > piq_pkg::ACC_W'(i_cfg.change_threshold)) begin
                        o_state.last_reported = iir_acc;
                        o_result.changed      = 1'b1;
                    end
                end
                default: begin
                    o_state.accumulator = piq_pkg::ACC_W'(sample[0]);
                end
            endcase
        end

        // Reported level in the current mode
        o_result.level_value = is_analog ? piq_pkg::LEVEL_W'(o_state.accumulator >> k)
                                         : o_state.accumulator[piq_pkg::LEVEL_W-1:0];
    end

endmodule

`default_nettype wire
